// ===== hw/rtl/sirs_pkg.sv =====
// Shared types, constants and helpers for the signed integer to radix symbol converter.
// Used by sirs_alpha_check, sirs_divider and signed_int_to_radix_symbols_top.
package sirs_pkg;

    // Alphabet limits and special bytes
    localparam int unsigned MAX_SYMBOLS = 16;
    localparam int unsigned SYM_W       = 8;
    localparam int unsigned SYM_IDX_W   = 4;
    localparam int unsigned RADIX_W     = 5;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_ADDR_W  = 2;

    localparam logic [SYM_W-1:0] MINUS_SIGN  = 8'h2D;
    localparam logic [SYM_W-1:0] PLUS_SIGN   = 8'h2B;
    localparam logic [SYM_W-1:0] SPACE_LIMIT = 8'd32;
    localparam logic [SYM_W-1:0] HIGH_LIMIT  = 8'd128;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE_LENGTH   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

    // Result of one alphabet validation pass
    typedef struct packed {
        logic done;
        logic ok;
    } chk_status_t;

    // Result of one digit division
    typedef struct packed {
        logic done;
        logic quot_zero;
    } div_status_t;

    // Pick symbol idx out of the two packed alphabet words
    function automatic logic [SYM_W-1:0] sym_at(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [SYM_IDX_W-1:0]  idx
    );
        logic [CFG_DATA_W-1:0] word;
        word = idx[SYM_IDX_W-1] ? hi : lo;
        return word[idx[SYM_IDX_W-2:0]*SYM_W +: SYM_W];
    endfunction

endpackage

// ===== hw/rtl/sirs_alpha_check.sv =====
// Alphabet validator: walks the 16 symbol slots one per cycle after a start pulse.
// Depends on sirs_pkg (sym_at, limits, chk_status_t).
module sirs_alpha_check (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [sirs_pkg::RADIX_W-1:0]    base_length,
    input  logic [sirs_pkg::CFG_DATA_W-1:0] alphabet_low,
    input  logic [sirs_pkg::CFG_DATA_W-1:0] alphabet_high,
    output sirs_pkg::chk_status_t           status
);
    import sirs_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 ok_reg, ok_next;
    logic [SYM_IDX_W-1:0] idx_reg, idx_next;

    logic [SYM_W-1:0]     cur_sym;
    logic                 in_use;
    logic                 dup;
    logic                 bad;
    logic                 range_ok;

    // Radix must lie in 2..MAX_SYMBOLS
    assign range_ok = (base_length >= RADIX_W'(2)) && (base_length <= RADIX_W'(MAX_SYMBOLS));

    // Check the current slot against the forbidden bytes and every later slot in use
    always_comb
    begin
        cur_sym = sym_at(alphabet_low, alphabet_high, idx_reg);
        in_use  = {1'b0, idx_reg} < base_length;
        dup     = 1'b0;
        for (int j = 0; j < 16; j++)
        begin
            if ((SYM_IDX_W'(j) > idx_reg) && (RADIX_W'(j) < base_length) &&
                (sym_at(alphabet_low, alphabet_high, SYM_IDX_W'(j)) == cur_sym))
            begin
                dup = 1'b1;
            end
        end
        bad = in_use && ((cur_sym == PLUS_SIGN) || (cur_sym == MINUS_SIGN) ||
                         (cur_sym <= SPACE_LIMIT) || (cur_sym >= HIGH_LIMIT) || dup);
    end

    // Advance the slot index, accumulate the verdict
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ok_next   = ok_reg;
        idx_next  = idx_reg;
        if (start)
        begin
            busy_next = 1'b1;
            ok_next   = range_ok;
            idx_next  = '0;
        end
        else if (busy_reg)
        begin
            ok_next  = ok_reg && !bad;
            idx_next = idx_reg + 1'b1;
            if (idx_reg == '1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ok_reg   <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ok_reg   <= ok_next;
            idx_reg  <= idx_next;
        end
    end

    assign status.done = done_reg;
    assign status.ok   = ok_reg;

endmodule

// ===== hw/rtl/sirs_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, one radix digit per division.
// Depends on sirs_pkg (RADIX_W, SYM_IDX_W, div_status_t).
module sirs_divider #(
    parameter int unsigned WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [WIDTH-1:0]               dividend,
    input  logic [sirs_pkg::RADIX_W-1:0]   radix,
    output logic [WIDTH-1:0]               quotient,
    output logic [sirs_pkg::SYM_IDX_W-1:0] remainder,
    output sirs_pkg::div_status_t          status
);
    import sirs_pkg::*;

    localparam int unsigned CNT_W = $clog2(WIDTH + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic                 zero_reg, zero_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WIDTH-1:0]     quot_reg, quot_next;
    logic [SYM_IDX_W-1:0] rem_reg, rem_next;

    logic [RADIX_W-1:0]   trial;
    logic                 fits;
    logic [WIDTH-1:0]     quot_shift;
    logic [RADIX_W-1:0]   trial_diff;

    // One restoring step: bring down the top dividend bit, subtract if it fits
    assign trial      = {rem_reg, quot_reg[WIDTH-1]};
    assign fits       = trial >= radix;
    assign trial_diff = trial - radix;
    assign quot_shift = {quot_reg[WIDTH-2:0], fits};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quot_next = quot_shift;
            rem_next  = fits ? trial_diff[SYM_IDX_W-1:0] : trial[SYM_IDX_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                zero_next = (quot_shift == '0);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            zero_reg <= zero_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shift registers for quotient and partial remainder
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign quotient         = quot_reg;
    assign remainder        = rem_reg;
    assign status.done      = done_reg;
    assign status.quot_zero = zero_reg;

endmodule

// ===== hw/rtl/signed_int_to_radix_symbols_top.sv =====
// Signed number to radix symbols: writes each accepted number out as alphabet bytes,
// most significant digit first, leading '-' for negatives, last flag on the final byte.
// A number passes the alphabet check, then one bit-serial division per digit, then for
// each output byte the read, load and send states, the send state waiting while the sink
// is not ready. With an invalid alphabet the word yields no bytes and the block is ready
// again after the check. Depends on sirs_pkg, sirs_alpha_check, sirs_divider.
module signed_int_to_radix_symbols_top #(
    parameter int unsigned NUMBER_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sirs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [sirs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [NUMBER_WIDTH-1:0]   number,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sirs_pkg::SYM_W-1:0]       symbol,
    output logic                             last
);
    import sirs_pkg::*;

    localparam int unsigned CNT_W  = $clog2(NUMBER_WIDTH + 1);
    localparam int unsigned ADDR_W = $clog2(NUMBER_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SIGN,
        S_READ,
        S_LOAD,
        S_SEND
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  out_valid_reg;
    logic [SYM_W-1:0]      symbol_reg;
    logic                  last_reg;

    logic [RADIX_W-1:0]    base_length_reg;
    logic [CFG_DATA_W-1:0] alphabet_low_reg;
    logic [CFG_DATA_W-1:0] alphabet_high_reg;

    logic [NUMBER_WIDTH-1:0] num_reg;
    logic [NUMBER_WIDTH-1:0] magnitude;
    logic                    negative;

    logic [SYM_IDX_W-1:0]  digit_mem [NUMBER_WIDTH];
    logic [SYM_IDX_W-1:0]  rd_data_reg;
    logic [CNT_W-1:0]      cnt_inc;
    logic [CNT_W-1:0]      cnt_dec;
    logic                  mem_we;

    logic                    in_take;
    logic                    out_take;
    chk_status_t             chk_st;
    div_status_t             div_st;
    logic                    div_start;
    logic [NUMBER_WIDTH-1:0] div_dividend;
    logic [NUMBER_WIDTH-1:0] div_quot;
    logic [SYM_IDX_W-1:0]    div_rem;
    logic                    digits_done;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid_reg && out_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg   <= '0;
            alphabet_low_reg  <= '0;
            alphabet_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_BASE_LENGTH:   base_length_reg   <= cfg_wdata[RADIX_W-1:0];
                CFG_ALPHABET_LOW:  alphabet_low_reg  <= cfg_wdata;
                CFG_ALPHABET_HIGH: alphabet_high_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Hold the accepted word
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            num_reg <= $unsigned(number);
        end
    end

    assign negative  = num_reg[NUMBER_WIDTH-1];
    assign magnitude = negative ? (~num_reg + NUMBER_WIDTH'(1)) : num_reg;

    sirs_alpha_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (in_take),
        .base_length   (base_length_reg),
        .alphabet_low  (alphabet_low_reg),
        .alphabet_high (alphabet_high_reg),
        .status        (chk_st)
    );

    // First digit divides the magnitude, later ones the previous quotient
    assign cnt_inc      = cnt_reg + 1'b1;
    assign cnt_dec      = cnt_reg - 1'b1;
    assign digits_done  = div_st.quot_zero || (cnt_inc == CNT_W'(NUMBER_WIDTH));
    assign mem_we       = (state_reg == S_DIV) && div_st.done;
    assign div_start    = ((state_reg == S_CHECK) && chk_st.done && chk_st.ok) ||
                          (mem_we && !digits_done);
    assign div_dividend = (state_reg == S_CHECK) ? magnitude : div_quot;

    sirs_divider #(
        .WIDTH (NUMBER_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .radix     (base_length_reg),
        .quotient  (div_quot),
        .remainder (div_rem),
        .status    (div_st)
    );

    // Digit store, least significant digit at address zero
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[cnt_reg[ADDR_W-1:0]] <= div_rem;
        end
        rd_data_reg <= digit_mem[cnt_dec[ADDR_W-1:0]];
    end

    // Sequencer with registered output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            symbol_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (chk_st.done)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= chk_st.ok ? S_DIV : S_IDLE;
                    end
                end
                S_DIV:
                begin
                    if (div_st.done)
                    begin
                        cnt_reg <= cnt_inc;
                        if (digits_done)
                        begin
                            if (negative)
                            begin
                                symbol_reg    <= MINUS_SIGN;
                                last_reg      <= 1'b0;
                                out_valid_reg <= 1'b1;
                                state_reg     <= S_SIGN;
                            end
                            else
                            begin
                                state_reg <= S_READ;
                            end
                        end
                    end
                end
                S_SIGN:
                begin
                    if (out_take)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_READ;
                    end
                end
                S_READ:
                begin
                    cnt_reg   <= cnt_dec;
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    symbol_reg    <= sym_at(alphabet_low_reg, alphabet_high_reg, rd_data_reg);
                    last_reg      <= (cnt_reg == '0);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_SEND;
                end
                S_SEND:
                begin
                    if (out_take)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= (cnt_reg == '0) ? S_IDLE : S_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;

    // Output word only shows while waiting on the sink
    a_valid_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((state_reg == S_SIGN) || (state_reg == S_SEND)))
        else $error("output valid outside a send state");

    // Never take a new word while bytes are pending
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid_reg)
        else $error("input ready while output pending");

    // Digit count stays within the store
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (cnt_reg < CNT_W'(NUMBER_WIDTH)))
        else $error("digit store overflow");

    // The final byte returns the block to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && last_reg) |=> (state_reg == S_IDLE))
        else $error("last byte did not end the word");

endmodule
